// ===== rtl/core/tape_machine_instruction_step_top_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef TAPE_MACHINE_INSTRUCTION_STEP_TOP_MACROS_SVH
`define TAPE_MACHINE_INSTRUCTION_STEP_TOP_MACROS_SVH

// Clocked assertion with an active-low disable.
`define TPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block clock and reset.
`define TPS_ASSERT_AC(lbl, prop, msg) \
    `TPS_ASSERT(lbl, aclk, aresetn, prop, msg)

`endif

// ===== rtl/core/tps_pkg.sv =====
package tps_pkg;

    localparam int PROG_DEPTH = 4096;
    localparam int DATA_DEPTH = 32768;
    localparam int PAW        = $clog2(PROG_DEPTH);
    localparam int DAW        = $clog2(DATA_DEPTH);
    localparam int CLR_DEPTH  = (DATA_DEPTH > PROG_DEPTH) ? DATA_DEPTH : PROG_DEPTH;
    localparam int CLR_AW     = $clog2(CLR_DEPTH);
    localparam int ADDR_W     = 12;
    localparam int BYTE_W     = 8;

    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_STEP,
        KIND_SET,
        KIND_NONE
    } kind_t;

    typedef enum logic [1:0] {
        STAT_DONE,
        STAT_ENDED,
        STAT_REJECT
    } status_t;

    typedef struct packed {
        logic              we;
        logic [PAW-1:0]    waddr;
        logic [BYTE_W-1:0] wdata;
        logic [PAW-1:0]    raddr;
    } prog_req_t;

    typedef struct packed {
        logic              we;
        logic [DAW-1:0]    waddr;
        logic [BYTE_W-1:0] wdata;
        logic [DAW-1:0]    raddr;
    } data_req_t;

    // The last code cell always reads as the terminator.
    function automatic logic [BYTE_W-1:0] fetch_byte(input logic [PAW-1:0] a,
                                                     input logic [BYTE_W-1:0] rd);
        fetch_byte = (32'(a) >= PROG_DEPTH - 1) ? '0 : rd;
    endfunction

    function automatic logic is_cmd(input logic [BYTE_W-1:0] c);
        is_cmd = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_LT) || (c == CH_GT) ||
                 (c == CH_OPEN) || (c == CH_CLOSE) || (c == CH_COMMA) || (c == CH_DOT);
    endfunction

endpackage

// ===== rtl/core/tps_prog_mem.sv =====
module tps_prog_mem (
    input  logic                       aclk,
    input  tps_pkg::prog_req_t         req,
    output logic [tps_pkg::BYTE_W-1:0] rdata
);
    import tps_pkg::*;

    logic [BYTE_W-1:0] mem [PROG_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.we && (req.waddr == req.raddr)) begin
            rdata_reg <= req.wdata;
        end else begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/tps_data_mem.sv =====
module tps_data_mem (
    input  logic                       aclk,
    input  tps_pkg::data_req_t         req,
    output logic [tps_pkg::BYTE_W-1:0] rdata
);
    import tps_pkg::*;

    logic [BYTE_W-1:0] mem [DATA_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.we && (req.waddr == req.raddr)) begin
            rdata_reg <= req.wdata;
        end else begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/tape_machine_instruction_step_top.sv =====
// Eight-command tape machine stepper. Program bytes and data cells live in two
// single-port-write synchronous RAMs with registered reads. After reset the block
// zeroes both stores, one entry per cycle, over 32768 entries (the data store depth),
// and accepts no transaction until that pass ends. Each transaction returns one
// result. A load writes its byte in the load state, then returns; a step runs an
// ordinary command in the execute state, then skips the non-command bytes after
// it; a bracket jump walks program bytes to the matching bracket; a set-ip walks
// the program from address 0 up to the new value, one byte per cycle, rejecting
// if it meets the terminator first. The program RAM reads one byte per cycle. A new
// transaction is taken while the previous result still waits on the output.
module tape_machine_instruction_step_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_kind,
    input  logic [tps_pkg::ADDR_W-1:0] s_address,
    input  logic [tps_pkg::BYTE_W-1:0] s_code_byte,
    input  logic [tps_pkg::BYTE_W-1:0] s_in_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic                       m_out_valid,
    output logic [tps_pkg::BYTE_W-1:0] m_out_byte,
    output logic                       m_in_used,
    output logic [tps_pkg::ADDR_W-1:0] m_ip_now,
    output logic                       m_at_end
);
    import tps_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_LOAD, ST_SET, ST_EXEC, ST_FWD, ST_BACK, ST_SKIP, ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [CLR_AW-1:0]  clr_reg, clr_next;
    logic [PAW-1:0]     ip_reg, ip_next;
    logic [DAW-1:0]     dp_reg, dp_next;
    logic [PAW:0]       depth_reg, depth_next;
    logic [PAW-1:0]     idx_reg, idx_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [BYTE_W-1:0]  code_reg, code_next;
    logic [BYTE_W-1:0]  inb_reg, inb_next;
    status_t            res_status_reg, res_status_next;
    logic               res_ovalid_reg, res_ovalid_next;
    logic [BYTE_W-1:0]  res_obyte_reg, res_obyte_next;
    logic               res_used_reg, res_used_next;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic               m_ovalid_reg, m_ovalid_next;
    logic [BYTE_W-1:0]  m_obyte_reg, m_obyte_next;
    logic               m_used_reg, m_used_next;
    logic [ADDR_W-1:0]  m_ip_reg, m_ip_next;
    logic               m_end_reg, m_end_next;

    prog_req_t          preq;
    data_req_t          dreq;
    logic [BYTE_W-1:0]  prog_rdata;
    logic [BYTE_W-1:0]  data_rdata;
    logic [BYTE_W-1:0]  cur;
    logic [BYTE_W-1:0]  scan;

    tps_prog_mem u_prog (.aclk(aclk), .req(preq), .rdata(prog_rdata));
    tps_data_mem u_data (.aclk(aclk), .req(dreq), .rdata(data_rdata));

    assign s_ready = (state_reg == ST_IDLE);
    assign cur     = fetch_byte(ip_reg, prog_rdata);
    assign scan    = fetch_byte(idx_reg, prog_rdata);

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        ip_next         = ip_reg;
        dp_next         = dp_reg;
        depth_next      = depth_reg;
        idx_next        = idx_reg;
        addr_next       = addr_reg;
        code_next       = code_reg;
        inb_next        = inb_reg;
        res_status_next = res_status_reg;
        res_ovalid_next = res_ovalid_reg;
        res_obyte_next  = res_obyte_reg;
        res_used_next   = res_used_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_ovalid_next   = m_ovalid_reg;
        m_obyte_next    = m_obyte_reg;
        m_used_next     = m_used_reg;
        m_ip_next       = m_ip_reg;
        m_end_next      = m_end_reg;
        preq            = '0;
        dreq            = '0;
        preq.waddr      = PAW'(addr_reg);
        preq.wdata      = code_reg;
        dreq.waddr      = dp_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                preq.we    = (32'(clr_reg) < PROG_DEPTH);
                preq.waddr = PAW'(clr_reg);
                dreq.we    = (32'(clr_reg) < DATA_DEPTH);
                dreq.waddr = DAW'(clr_reg);
                clr_next   = clr_reg + 1'b1;
                if (32'(clr_reg) == CLR_DEPTH - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    addr_next       = s_address;
                    code_next       = s_code_byte;
                    inb_next        = s_in_byte;
                    res_status_next = STAT_DONE;
                    res_ovalid_next = 1'b0;
                    res_obyte_next  = '0;
                    res_used_next   = 1'b0;
                    depth_next      = '0;
                    unique case (kind_t'(s_kind))
                        KIND_LOAD: state_next = ST_LOAD;
                        KIND_STEP: state_next = ST_EXEC;
                        KIND_SET: begin
                            if (s_address == '0) begin
                                ip_next    = '0;
                                state_next = ST_DONE;
                            end else begin
                                idx_next   = '0;
                                state_next = ST_SET;
                            end
                        end
                        KIND_NONE: state_next = ST_DONE;
                    endcase
                end
            end
            ST_LOAD: begin
                preq.we    = (32'(addr_reg) < PROG_DEPTH);
                state_next = ST_DONE;
            end
            ST_SET: begin
                if (scan == '0) begin
                    res_status_next = STAT_REJECT;
                    state_next      = ST_DONE;
                end else if (ADDR_W'(idx_reg + 1'b1) == addr_reg) begin
                    ip_next    = PAW'(addr_reg);
                    state_next = ST_DONE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_EXEC: begin
                state_next = ST_SKIP;
                unique case (cur)
                    8'h00: begin
                        res_status_next = STAT_ENDED;
                        state_next      = ST_DONE;
                    end
                    CH_PLUS: begin
                        dreq.we    = 1'b1;
                        dreq.wdata = data_rdata + 1'b1;
                        ip_next    = ip_reg + 1'b1;
                    end
                    CH_MINUS: begin
                        dreq.we    = 1'b1;
                        dreq.wdata = data_rdata - 1'b1;
                        ip_next    = ip_reg + 1'b1;
                    end
                    CH_COMMA: begin
                        dreq.we       = 1'b1;
                        dreq.wdata    = inb_reg;
                        res_used_next = 1'b1;
                        ip_next       = ip_reg + 1'b1;
                    end
                    CH_DOT: begin
                        res_ovalid_next = 1'b1;
                        res_obyte_next  = data_rdata;
                        ip_next         = ip_reg + 1'b1;
                    end
                    CH_GT: begin
                        if (32'(dp_reg) < DATA_DEPTH - 2) begin
                            dp_next = dp_reg + 1'b1;
                        end
                        ip_next = ip_reg + 1'b1;
                    end
                    CH_LT: begin
                        if (dp_reg != '0) begin
                            dp_next = dp_reg - 1'b1;
                        end
                        ip_next = ip_reg + 1'b1;
                    end
                    CH_OPEN: begin
                        ip_next = ip_reg + 1'b1;
                        if (data_rdata == '0) begin
                            state_next = ST_FWD;
                        end
                    end
                    CH_CLOSE: begin
                        if (ip_reg != '0) begin
                            ip_next    = ip_reg - 1'b1;
                            state_next = ST_BACK;
                        end
                    end
                    default: ;
                endcase
            end
            ST_FWD: begin
                priority if (cur == '0) begin
                    state_next = ST_DONE;
                end else if (cur == CH_OPEN) begin
                    depth_next = depth_reg + 1'b1;
                    ip_next    = ip_reg + 1'b1;
                end else if (cur == CH_CLOSE) begin
                    ip_next = ip_reg + 1'b1;
                    if (depth_reg == '0) begin
                        state_next = ST_SKIP;
                    end else begin
                        depth_next = depth_reg - 1'b1;
                    end
                end else begin
                    ip_next = ip_reg + 1'b1;
                end
            end
            ST_BACK: begin
                if ((cur == CH_OPEN) && (depth_reg == '0)) begin
                    state_next = ST_SKIP;
                end else begin
                    if (cur == CH_CLOSE) begin
                        depth_next = depth_reg + 1'b1;
                    end else if (cur == CH_OPEN) begin
                        depth_next = depth_reg - 1'b1;
                    end
                    if (ip_reg == '0) begin
                        state_next = ST_SKIP;
                    end else begin
                        ip_next = ip_reg - 1'b1;
                    end
                end
            end
            ST_SKIP: begin
                if ((cur == '0) || is_cmd(cur)) begin
                    state_next = ST_DONE;
                end else begin
                    ip_next = ip_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_ovalid_next = res_ovalid_reg;
                    m_obyte_next  = res_obyte_reg;
                    m_used_next   = res_used_reg;
                    m_ip_next     = ADDR_W'(ip_reg);
                    m_end_next    = (cur == '0);
                    state_next    = ST_IDLE;
                end
            end
        endcase

        preq.raddr = (state_next == ST_SET) ? idx_next : ip_next;
        dreq.raddr = dp_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            ip_reg      <= '0;
            dp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            ip_reg      <= ip_next;
            dp_reg      <= dp_next;
            m_valid_reg <= m_valid_next;
        end
        depth_reg      <= depth_next;
        idx_reg        <= idx_next;
        addr_reg       <= addr_next;
        code_reg       <= code_next;
        inb_reg        <= inb_next;
        res_status_reg <= res_status_next;
        res_ovalid_reg <= res_ovalid_next;
        res_obyte_reg  <= res_obyte_next;
        res_used_reg   <= res_used_next;
        m_status_reg   <= m_status_next;
        m_ovalid_reg   <= m_ovalid_next;
        m_obyte_reg    <= m_obyte_next;
        m_used_reg     <= m_used_next;
        m_ip_reg       <= m_ip_next;
        m_end_reg      <= m_end_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_out_valid = m_ovalid_reg;
    assign m_out_byte  = m_obyte_reg;
    assign m_in_used   = m_used_reg;
    assign m_ip_now    = m_ip_reg;
    assign m_at_end    = m_end_reg;

endmodule

// ===== rtl/core/tps_checker.sv =====
`include "tape_machine_instruction_step_top_macros.svh"

module tps_props (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [1:0]                 m_status,
    input logic                       m_out_valid,
    input logic [tps_pkg::BYTE_W-1:0] m_out_byte,
    input logic                       m_in_used,
    input logic [tps_pkg::ADDR_W-1:0] m_ip_now,
    input logic                       m_at_end
);
    import tps_pkg::*;

    `TPS_ASSERT_AC(a_hold_result, m_valid && !m_ready |=> m_valid && $stable(m_ip_now), "result dropped while stalled")
    `TPS_ASSERT_AC(a_byte_quiet, m_valid && !m_out_valid |-> m_out_byte == '0, "out byte set without dot")
    `TPS_ASSERT_AC(a_ended_at_end, m_valid && m_status == STAT_ENDED |-> m_at_end, "ended status off terminator")
    `TPS_ASSERT_AC(a_one_effect, m_valid && m_in_used |-> !m_out_valid && m_status == STAT_DONE, "comma result mixed with other effects")

endmodule

bind tape_machine_instruction_step_top tps_props u_tps_props (.*);
